@@ design/fc2tc_pkg.sv @@
// ============================================================================
// fc2tc_pkg
// Shared widths, constants, register codes and the division step used by the
// frame count to SMPTE timecode converter.
// ============================================================================
package fc2tc_pkg;

    // Input frame position width; the sign bit is FRAME_BITS-1.
    localparam int FRAME_BITS = 32;
    localparam int MAG_W      = FRAME_BITS;

    // Output field widths.
    localparam int HOURS_W  = 20;
    localparam int MINS_W   = 6;
    localparam int SECS_W   = 6;
    localparam int FRAMES_W = 7;

    // Configuration port.
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_RATE = 2'd0,
        CFG_DROP_FRAME = 2'd1,
        CFG_ALLOW_NEG  = 2'd2,
        CFG_WRAP_HOURS = 2'd3
    } cfg_idx_t;

    // Timecode constants.
    localparam int SECS_PER_MIN    = 60;
    localparam int MINS_PER_HOUR   = 60;
    localparam int HOURS_PER_DAY   = 24;
    localparam int HOUR_LAST       = HOURS_PER_DAY - 1;
    localparam int MINS_PER_BLOCK  = 10;
    localparam int SECS_PER_BLOCK  = SECS_PER_MIN * MINS_PER_BLOCK;
    localparam int DROP_PER_MIN    = 2;
    localparam int DROP_PER_BLOCK  = (MINS_PER_BLOCK - 1) * DROP_PER_MIN;
    localparam int HOURS_MAX       = (1 << HOURS_W) - 1;

    // Reset values of the configuration and of the derived divisors.
    localparam int FR_RESET        = 30;
    localparam int PER_MIN_RESET   = FR_RESET * SECS_PER_MIN - DROP_PER_MIN;
    localparam int PER_BLOCK_RESET = FR_RESET * SECS_PER_BLOCK - DROP_PER_BLOCK;

    // Divisor widths: frames per drop minute and per ten-minute block at 127 fps.
    localparam int PER_MIN_W = 13;
    localparam int REM_W     = 17;
    localparam int HOURS_Q_W = HOURS_W + 1;

    // Restoring division steps per stage group. Each group starts its
    // remainder from the numerator bits that are known to be below the
    // divisor, so only the quotient bits that can be set get a stage.
    localparam int A_STEPS = 22;              // magnitude / frames per block
    localparam int A_INIT  = MAG_W - A_STEPS; // leading magnitude bits
    localparam int B_STEPS = 4;               // block remainder / frames per minute
    localparam int C_STEPS = MAG_W;           // nominal / frame rate
    localparam int D_STEPS = 27;              // seconds / 60
    localparam int E_STEPS = 21;              // minutes / 60
    localparam int G_STEPS = 17;              // hours mod 24

    // Stage map.
    localparam int ST_IN    = 0;
    localparam int ST_PREP  = ST_IN + A_STEPS + 1;
    localparam int ST_NOM   = ST_PREP + B_STEPS + 1;
    localparam int ST_FRM   = ST_NOM + C_STEPS + 1;
    localparam int ST_SEC   = ST_FRM + D_STEPS + 1;
    localparam int ST_MIN   = ST_SEC + E_STEPS + 1;
    localparam int ST_OUT   = ST_MIN + G_STEPS + 1;
    localparam int N_STAGES = ST_OUT + 1;

    // Output queue.
    localparam int Q_DEPTH = 2;

    // Item state carried down the pipeline.
    typedef struct packed {
        logic                 neg;
        logic [MAG_W-1:0]     mag;
        logic [MAG_W-1:0]     num;
        logic [REM_W-1:0]     rem;
        logic [MAG_W-1:0]     quo;
        logic [MAG_W-1:0]     base;
        logic [HOURS_Q_W-1:0] hours;
        logic [MINS_W-1:0]    mins;
        logic [SECS_W-1:0]    secs;
        logic [FRAMES_W-1:0]  frames;
    } pipe_t;

    // One finished timecode.
    typedef struct packed {
        logic [HOURS_W-1:0]  hours;
        logic [MINS_W-1:0]   mins;
        logic [SECS_W-1:0]   secs;
        logic [FRAMES_W-1:0] frames;
        logic                neg;
    } res_t;

    // One restoring division step: shift in a numerator bit, subtract the
    // divisor if it fits. Returns {quotient bit, new remainder}.
    function automatic logic [REM_W:0] div_step(
        input logic [REM_W-1:0] rem,
        input logic             nbit,
        input logic [REM_W-1:0] dvs
    );
        logic [REM_W:0] t;
        logic [REM_W:0] d;
        logic           q;
        t = {rem, nbit};
        d = {1'b0, dvs};
        q = (t >= d);
        if (q)
        begin
            t = t - d;
        end
        return {q, t[REM_W-1:0]};
    endfunction

endpackage

@@ design/fc2tc_if.sv @@
// ============================================================================
// fc2tc channel interfaces
// Valid/ready channels for frame positions and for finished timecodes.
// ============================================================================
interface fc2tc_count_if
    import fc2tc_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [FRAME_BITS-1:0] frame_count;

    modport source (output valid, output frame_count, input ready);
    modport sink   (input valid, input frame_count, output ready);
endinterface

interface fc2tc_tc_if
    import fc2tc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [HOURS_W-1:0]  hours_out;
    logic [MINS_W-1:0]   minutes_out;
    logic [SECS_W-1:0]   seconds_out;
    logic [FRAMES_W-1:0] frames_out;
    logic                negative_flag;

    modport source (output valid, output hours_out, output minutes_out,
                    output seconds_out, output frames_out, output negative_flag,
                    input ready);
    modport sink   (input valid, input hours_out, input minutes_out,
                    input seconds_out, input frames_out, input negative_flag,
                    output ready);
endinterface

@@ design/frame_count_to_smpte_timecode_top.sv @@
// ============================================================================
// frame_count_to_smpte_timecode_top
// Converts signed frame positions to hours:minutes:seconds:frames timecode,
// with optional drop-frame renumbering and a 24-hour wrap.
//
// count_ch carries one signed frame position per item; timecode_ch returns
// one timecode item per position, in order. Configuration goes through a
// plain write port (cfg_we, cfg_index, cfg_wdata); the user must write it
// only while no item is in flight; the block itself does not enforce this. One
// item is accepted every cycle while the output queue has room. Each division
// stage does one restoring step (one compare and subtract); the six divisions
// are laid end to end: 123 such stages plus seven setup and finishing stages.
// A two-entry output queue holds finished items; the pipeline advances as a
// whole whenever the queue has room, so count_ch.ready drops only after the
// receiver has stalled long enough to fill it. Nothing is lost or repeated.
// Reset empties the pipeline and queue and restores 30 fps, non-drop,
// negatives flagged and hours wrapped at 24.
// ============================================================================
module frame_count_to_smpte_timecode_top
    import fc2tc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    fc2tc_count_if.sink           count_ch,
    fc2tc_tc_if.source            timecode_ch
);

    // ------------------------------------------------------------------------
    // Configuration, kept as the divisors the pipeline needs
    // ------------------------------------------------------------------------
    logic [FRAMES_W-1:0]  fr_eff_reg;
    logic [PER_MIN_W-1:0] per_min_reg;
    logic [REM_W-1:0]     per_block_reg;
    logic                 drop_reg;
    logic                 allow_neg_reg;
    logic                 wrap_reg;
    logic [FRAMES_W-1:0]  fr_w;

    // A zero rate counts as one frame per second.
    assign fr_w = (cfg_wdata == '0) ? FRAMES_W'(1) : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_eff_reg    <= FRAMES_W'(FR_RESET);
            per_min_reg   <= PER_MIN_W'(PER_MIN_RESET);
            per_block_reg <= REM_W'(PER_BLOCK_RESET);
            drop_reg      <= 1'b0;
            allow_neg_reg <= 1'b1;
            wrap_reg      <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME_RATE:
                begin
                    fr_eff_reg    <= fr_w;
                    per_min_reg   <= PER_MIN_W'(fr_w) * PER_MIN_W'(SECS_PER_MIN)
                                     - PER_MIN_W'(DROP_PER_MIN);
                    per_block_reg <= REM_W'(fr_w) * REM_W'(SECS_PER_BLOCK)
                                     - REM_W'(DROP_PER_BLOCK);
                end
                CFG_DROP_FRAME: drop_reg      <= cfg_wdata[0];
                CFG_ALLOW_NEG:  allow_neg_reg <= cfg_wdata[0];
                CFG_WRAP_HOURS: wrap_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline
    // ------------------------------------------------------------------------
    pipe_t pipe_reg  [N_STAGES];
    pipe_t pipe_next [N_STAGES];
    logic  valid_reg [N_STAGES];

    logic [1:0] q_count_reg;
    logic       adv;
    logic       push;
    logic       pop;

    // Advance everything together while the output queue has room.
    assign adv            = (q_count_reg != 2'(Q_DEPTH));
    assign count_ch.ready = adv;

    // Entry: take the magnitude and seed the block division.
    always_comb
    begin
        logic [MAG_W-1:0] v;
        logic [MAG_W-1:0] m;
        v = MAG_W'(count_ch.frame_count);
        m = v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
        pipe_next[ST_IN]      = '0;
        pipe_next[ST_IN].neg  = v[MAG_W-1];
        pipe_next[ST_IN].mag  = m;
        pipe_next[ST_IN].rem  = REM_W'(m[MAG_W-1:A_STEPS]);
        pipe_next[ST_IN].num  = {m[A_STEPS-1:0], {A_INIT{1'b0}}};
        pipe_next[ST_IN].quo  = '0;
    end

    for (genvar k = 1; k < N_STAGES; k++)
    begin : g_stage
        if (k == ST_PREP)
        begin : g_prep
            // Blocks are in quo, the remainder within the block in rem.
            always_comb
            begin
                logic [MAG_W-1:0] blk18;
                logic [REM_W-1:0] x;
                blk18 = {6'b0, pipe_reg[k-1].quo[A_STEPS-1:0], 4'b0}
                        + {9'b0, pipe_reg[k-1].quo[A_STEPS-1:0], 1'b0};
                x = (drop_reg && pipe_reg[k-1].rem > REM_W'(DROP_PER_MIN))
                    ? pipe_reg[k-1].rem - REM_W'(DROP_PER_MIN) : '0;
                pipe_next[k]      = pipe_reg[k-1];
                pipe_next[k].base = drop_reg ? pipe_reg[k-1].mag + blk18
                                             : pipe_reg[k-1].mag;
                pipe_next[k].rem  = REM_W'(x[REM_W-1:B_STEPS]);
                pipe_next[k].num  = {x[B_STEPS-1:0], {(MAG_W-B_STEPS){1'b0}}};
                pipe_next[k].quo  = '0;
            end
        end
        else if (k == ST_NOM)
        begin : g_nom
            // Add two frames per further minute and start the split by rate.
            always_comb
            begin
                pipe_next[k]     = pipe_reg[k-1];
                pipe_next[k].num = pipe_reg[k-1].base
                                   + {{(MAG_W-B_STEPS-1){1'b0}},
                                      pipe_reg[k-1].quo[B_STEPS-1:0], 1'b0};
                pipe_next[k].rem = '0;
                pipe_next[k].quo = '0;
            end
        end
        else if (k == ST_FRM)
        begin : g_frm
            always_comb
            begin
                pipe_next[k]        = pipe_reg[k-1];
                pipe_next[k].frames = pipe_reg[k-1].rem[FRAMES_W-1:0];
                pipe_next[k].rem    = REM_W'(pipe_reg[k-1].quo[MAG_W-1:D_STEPS]);
                pipe_next[k].num    = {pipe_reg[k-1].quo[D_STEPS-1:0],
                                       {(MAG_W-D_STEPS){1'b0}}};
                pipe_next[k].quo    = '0;
            end
        end
        else if (k == ST_SEC)
        begin : g_sec
            always_comb
            begin
                pipe_next[k]      = pipe_reg[k-1];
                pipe_next[k].secs = pipe_reg[k-1].rem[SECS_W-1:0];
                pipe_next[k].rem  = REM_W'(pipe_reg[k-1].quo[D_STEPS-1:E_STEPS]);
                pipe_next[k].num  = {pipe_reg[k-1].quo[E_STEPS-1:0],
                                     {(MAG_W-E_STEPS){1'b0}}};
                pipe_next[k].quo  = '0;
            end
        end
        else if (k == ST_MIN)
        begin : g_min
            always_comb
            begin
                pipe_next[k]       = pipe_reg[k-1];
                pipe_next[k].mins  = pipe_reg[k-1].rem[MINS_W-1:0];
                pipe_next[k].hours = pipe_reg[k-1].quo[HOURS_Q_W-1:0];
                pipe_next[k].rem   = REM_W'(pipe_reg[k-1].quo[HOURS_Q_W-1:G_STEPS]);
                pipe_next[k].num   = {pipe_reg[k-1].quo[G_STEPS-1:0],
                                      {(MAG_W-G_STEPS){1'b0}}};
                pipe_next[k].quo   = '0;
            end
        end
        else if (k == ST_OUT)
        begin : g_out
            // Wrap or fold the hours, else saturate them.
            always_comb
            begin
                logic [4:0] h;
                h = pipe_reg[k-1].rem[4:0];
                pipe_next[k] = pipe_reg[k-1];
                if (wrap_reg)
                begin
                    if (pipe_reg[k-1].neg && !allow_neg_reg)
                    begin
                        pipe_next[k].neg = 1'b0;
                        h = 5'(HOUR_LAST) - h;
                    end
                    pipe_next[k].hours = HOURS_Q_W'(h);
                end
                else if (pipe_reg[k-1].hours[HOURS_Q_W-1])
                begin
                    pipe_next[k].hours = HOURS_Q_W'(HOURS_MAX);
                end
            end
        end
        else
        begin : g_div
            logic [REM_W-1:0] dvs;
            logic [REM_W:0]   step;

            always_comb
            begin
                if (k < ST_PREP)
                begin
                    dvs = per_block_reg;
                end
                else if (k < ST_NOM)
                begin
                    dvs = REM_W'(per_min_reg);
                end
                else if (k < ST_FRM)
                begin
                    dvs = REM_W'(fr_eff_reg);
                end
                else if (k < ST_MIN)
                begin
                    dvs = REM_W'(SECS_PER_MIN);
                end
                else
                begin
                    dvs = REM_W'(HOURS_PER_DAY);
                end
                step = div_step(pipe_reg[k-1].rem, pipe_reg[k-1].num[MAG_W-1], dvs);
                pipe_next[k]     = pipe_reg[k-1];
                pipe_next[k].rem = step[REM_W-1:0];
                pipe_next[k].quo = {pipe_reg[k-1].quo[MAG_W-2:0], step[REM_W]};
                pipe_next[k].num = {pipe_reg[k-1].num[MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[ST_IN] <= count_ch.valid;
            for (int i = 1; i < N_STAGES; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N_STAGES; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------------
    res_t q_reg [Q_DEPTH];
    res_t res_in;
    res_t res_head;
    logic wr_ptr_reg;
    logic rd_ptr_reg;

    assign push = adv && valid_reg[ST_OUT];
    assign pop  = timecode_ch.valid && timecode_ch.ready;

    assign res_in.hours  = pipe_reg[ST_OUT].hours[HOURS_W-1:0];
    assign res_in.mins   = pipe_reg[ST_OUT].mins;
    assign res_in.secs   = pipe_reg[ST_OUT].secs;
    assign res_in.frames = pipe_reg[ST_OUT].frames;
    assign res_in.neg    = pipe_reg[ST_OUT].neg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            q_count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                q_count_reg <= q_count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                q_count_reg <= q_count_reg - 2'd1;
            end
        end
    end

    assign res_head                  = q_reg[rd_ptr_reg];
    assign timecode_ch.valid         = (q_count_reg != '0);
    assign timecode_ch.hours_out     = res_head.hours;
    assign timecode_ch.minutes_out   = res_head.mins;
    assign timecode_ch.seconds_out   = res_head.secs;
    assign timecode_ch.frames_out    = res_head.frames;
    assign timecode_ch.negative_flag = res_head.neg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_count_reg != 2'(Q_DEPTH)))
        else $error("item pushed into a full output queue");

    a_full_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count_reg == 2'(Q_DEPTH)) |=> ($stable(pipe_reg[ST_OUT])
                                          && $stable(valid_reg[ST_OUT])))
        else $error("last stage changed while the output queue was full");

    a_min_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        timecode_ch.valid |-> (timecode_ch.minutes_out < MINS_W'(MINS_PER_HOUR)
                               && timecode_ch.seconds_out < SECS_W'(SECS_PER_MIN)))
        else $error("minutes or seconds out of range");

endmodule
